FILE: sv/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths, defaults and control types for the sliding window median.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Field widths fixed by the data format.
    localparam int SAMPLE_W      = 32;
    localparam int WIN_SIZE_W    = 7;

    // Default window capacity and default register value.
    localparam int WINDOW_MAX_DEF = 64;
    localparam logic [WIN_SIZE_W-1:0] WIN_SIZE_RESET = 7'd1;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic insert;   // a sample transaction is taken this cycle
        logic restart;  // the window is emptied before this sample enters
        logic full;     // the window holds K samples, so one is evicted
        logic wipe;     // a window size write empties the window
    } t_cell_ctl;

endpackage

FILE: sv/swm_if.sv
// ----------------------------------------------------------------------------
// swm_if
// Valid/ready channel interfaces for samples, medians and the window size.
// ----------------------------------------------------------------------------
interface swm_sample_if;
    import swm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_median_if;
    import swm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

interface swm_cfg_if;
    import swm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [WIN_SIZE_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

FILE: sv/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// Lower median over the last K signed samples, built as a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on i_in, one per transaction, with a restart flag that
// empties the window before that sample enters. K is the window size
// register (written on i_cfg) limited to 1..WINDOW_MAX. Every write of the
// register also empties the window. Nothing is produced until K samples are
// held; from then on every sample yields one median on o_out.
// The window lives in a row of WINDOW_MAX cells kept in ascending order; each
// cell tracks the age of its sample, so the oldest is dropped and the new one
// inserted in the same cycle. One sample is accepted every clock cycle while
// i_in.ready is high; the cycle time is set by the eviction and compare ripple
// along the cell row. The median is registered into the output buffer, which
// presents it on o_out. A two-entry buffer keeps samples flowing while one
// median waits; i_in.ready drops only when both entries are occupied.
// Reset empties the window, clears the output buffer and sets K to 1.
// ----------------------------------------------------------------------------
module sliding_window_median #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    swm_sample_if.sink         i_in,
    swm_cfg_if.sink            i_cfg,
    swm_median_if.source       o_out
);
    import swm_pkg::*;

    localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    logic [WIN_SIZE_W-1:0] r_win_size;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic [CNT_W-1:0]      k_eff;
    logic [CNT_W-1:0]      k_minus1;
    logic [CNT_W-1:0]      mid_index;
    logic                  accept;
    logic                  cfg_write;
    logic                  full;
    logic                  emit;
    logic signed [SAMPLE_W-1:0] median_sel;
    t_cell_ctl             ctl;

    // Cell row wiring.
    logic signed [SAMPLE_W-1:0] c_value   [WINDOW_MAX];
    logic [AGE_W-1:0]           c_age     [WINDOW_MAX];
    logic                       c_valid   [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] c_w_value [WINDOW_MAX];
    logic [AGE_W-1:0]           c_w_age   [WINDOW_MAX];
    logic                       c_w_valid [WINDOW_MAX];
    logic                       c_gw      [WINDOW_MAX];
    logic                       c_evict   [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] c_upd     [WINDOW_MAX];

    // Output buffer.
    logic signed [SAMPLE_W-1:0] r_head, r_tail;
    logic                       r_head_valid, r_tail_valid;
    logic                       push, pop;

    assign accept    = i_in.valid && i_in.ready;
    assign cfg_write = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_tail_valid;

    // Effective window length.
    always_comb begin
        if (r_win_size == '0) begin
            k_eff = CNT_W'(1);
        end else if (32'(r_win_size) > 32'(WINDOW_MAX)) begin
            k_eff = CNT_W'(WINDOW_MAX);
        end else begin
            k_eff = CNT_W'(r_win_size);
        end
    end
    assign k_minus1  = k_eff - CNT_W'(1);
    assign mid_index = k_minus1 >> 1;

    // Fill count and median strobe.
    always_comb begin
        full = !i_in.restart && (r_fill == k_eff);
        if (i_in.restart) begin
            n_fill = CNT_W'(1);
        end else if (full) begin
            n_fill = k_eff;
        end else begin
            n_fill = r_fill + CNT_W'(1);
        end
        emit = accept && (n_fill == k_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_win_size <= WIN_SIZE_RESET;
        end else if (cfg_write) begin
            r_fill     <= '0;
            r_win_size <= i_cfg.window_size;
        end else if (accept) begin
            r_fill     <= n_fill;
        end
    end

    // Control broadcast to the cells.
    always_comb begin
        ctl.insert  = accept;
        ctl.restart = i_in.restart;
        ctl.full    = full;
        ctl.wipe    = cfg_write;
    end

    // Row of sorted cells.
    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic signed [SAMPLE_W-1:0] prev_w_value;
        logic [AGE_W-1:0]           prev_w_age;
        logic                       prev_w_valid;
        logic                       prev_gw;
        logic                       evict_in;
        logic signed [SAMPLE_W-1:0] next_value;
        logic [AGE_W-1:0]           next_age;
        logic                       next_valid;

        if (i == 0) begin : g_first
            assign prev_w_value = '0;
            assign prev_w_age   = '0;
            assign prev_w_valid = 1'b1;
            assign prev_gw      = 1'b0;
            assign evict_in     = 1'b0;
        end else begin : g_mid
            assign prev_w_value = c_w_value[i-1];
            assign prev_w_age   = c_w_age[i-1];
            assign prev_w_valid = c_w_valid[i-1];
            assign prev_gw      = c_gw[i-1];
            assign evict_in     = c_evict[i-1];
        end

        if (i == WINDOW_MAX - 1) begin : g_last
            assign next_value = '0;
            assign next_age   = '0;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_value = c_value[i+1];
            assign next_age   = c_age[i+1];
            assign next_valid = c_valid[i+1];
        end

        swm_cell #(
            .AGE_W (AGE_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (ctl),
            .i_sample       (i_in.sample),
            .i_k_minus1     (k_minus1),
            .i_prev_w_value (prev_w_value),
            .i_prev_w_age   (prev_w_age),
            .i_prev_w_valid (prev_w_valid),
            .i_prev_gw      (prev_gw),
            .i_next_value   (next_value),
            .i_next_age     (next_age),
            .i_next_valid   (next_valid),
            .i_evict_in     (evict_in),
            .o_evict_out    (c_evict[i]),
            .o_w_value      (c_w_value[i]),
            .o_w_age        (c_w_age[i]),
            .o_w_valid      (c_w_valid[i]),
            .o_gw           (c_gw[i]),
            .o_value        (c_value[i]),
            .o_age          (c_age[i]),
            .o_valid        (c_valid[i]),
            .o_upd_value    (c_upd[i])
        );
    end

    // Pick the updated value at the median slot.
    always_comb begin
        median_sel = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (CNT_W'(i) == mid_index) begin
                median_sel = median_sel | c_upd[i];
            end
        end
    end

    // Two-entry output buffer.
    assign push = emit;
    assign pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_tail_valid <= 1'b0;
        end else begin
            case ({push, pop})
                2'b10: begin
                    if (r_head_valid) begin
                        r_tail_valid <= 1'b1;
                    end else begin
                        r_head_valid <= 1'b1;
                    end
                end
                2'b01: begin
                    r_head_valid <= r_tail_valid;
                    r_tail_valid <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({push, pop})
            2'b10: begin
                if (r_head_valid) begin
                    r_tail <= median_sel;
                end else begin
                    r_head <= median_sel;
                end
            end
            2'b01: begin
                r_head <= r_tail;
            end
            2'b11: begin
                if (r_tail_valid) begin
                    r_head <= r_tail;
                    r_tail <= median_sel;
                end else begin
                    r_head <= median_sel;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid  = r_head_valid;
    assign o_out.median = r_head;

endmodule

FILE: sv/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: holds a value, its age and a valid bit, and
// moves values to or from its neighbors when a sample is inserted.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int AGE_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  swm_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [CNT_W-1:0]                   i_k_minus1,
    // Compacted view of the lower neighbor.
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_prev_w_value,
    input  logic [AGE_W-1:0]                   i_prev_w_age,
    input  logic                               i_prev_w_valid,
    input  logic                               i_prev_gw,
    // Stored state of the upper neighbor.
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_next_value,
    input  logic [AGE_W-1:0]                   i_next_age,
    input  logic                               i_next_valid,
    // Eviction seen at or below the lower neighbor.
    input  logic                               i_evict_in,
    output logic                               o_evict_out,
    // Compacted view of this cell for the upper neighbor.
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_w_value,
    output logic [AGE_W-1:0]                   o_w_age,
    output logic                               o_w_valid,
    output logic                               o_gw,
    // Stored state and its update value.
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_value,
    output logic [AGE_W-1:0]                   o_age,
    output logic                               o_valid,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_upd_value
);
    import swm_pkg::*;

    logic signed [SAMPLE_W-1:0] r_value, n_value;
    logic [AGE_W-1:0]           r_age, n_age;
    logic                       r_valid, n_valid;
    logic                       evict_here;
    logic                       evict_upto;

    // This cell holds the oldest sample of a full window.
    assign evict_here = i_ctl.full && r_valid &&
                        (CNT_W'(r_age) == i_k_minus1);
    assign evict_upto = i_evict_in | evict_here;

    // After removal of the evicted sample, cells above it move down by one.
    always_comb begin
        if (evict_upto) begin
            o_w_value = i_next_value;
            o_w_age   = i_next_age;
            o_w_valid = i_next_valid && !i_ctl.restart;
        end else begin
            o_w_value = r_value;
            o_w_age   = r_age;
            o_w_valid = r_valid && !i_ctl.restart;
        end
    end

    // An empty slot counts as larger than any sample.
    assign o_gw = !o_w_valid || (o_w_value > i_sample);

    // Insert the new sample: larger values move up by one slot.
    always_comb begin
        if (o_gw) begin
            if (i_prev_gw) begin
                n_value = i_prev_w_value;
                n_age   = i_prev_w_age + AGE_W'(1);
            end else begin
                n_value = i_sample;
                n_age   = '0;
            end
        end else begin
            n_value = o_w_value;
            n_age   = o_w_age + AGE_W'(1);
        end
        n_valid = o_w_valid | i_prev_w_valid;
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    // Occupancy bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.wipe) begin
            r_valid <= 1'b0;
        end else if (i_ctl.insert) begin
            r_valid <= n_valid;
        end
    end

    assign o_evict_out = evict_upto;
    assign o_value     = r_value;
    assign o_age       = r_age;
    assign o_valid     = r_valid;
    assign o_upd_value = n_value;

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sliding window lower-median filter.
// ----------------------------------------------------------------------------
// Samples are driven on the input channel and every accepted median is
// compared with a software copy of the window. The copy keeps the samples in
// arrival order and in ascending order. A short directed section covers
// extreme values, equal samples, restarts and a zero window size.
// A long random section follows, run over many window sizes, with random
// idle bursts on both channels. One long output stall fills the block's
// buffer, and one pause waits for the output to drain completely.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import swm_pkg::*;

    localparam int          TOTAL_ITEMS   = 1550;
    localparam int          QUIET_AFTER   = 1300;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD     = 80;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    // Software copy of the window; it queues the medians that the block owes.
    class median_tracker;
        logic signed [SAMPLE_W-1:0] ring [WINDOW_MAX_DEF];
        logic signed [SAMPLE_W-1:0] ordered [WINDOW_MAX_DEF];
        logic signed [SAMPLE_W-1:0] owed_medians [$];
        int unsigned                fill;
        int unsigned                oldest;
        int unsigned                k_eff;
        int                         failures;
        int                         medians_checked;

        function new();
            k_eff  = WIN_SIZE_RESET;
            fill   = 0;
            oldest = 0;
        endfunction

        // A window size write clamps K and empties the window.
        function void set_window(logic [WIN_SIZE_W-1:0] value);
            if (value == 0)
                k_eff = 1;
            else if (value > WINDOW_MAX_DEF)
                k_eff = WINDOW_MAX_DEF;
            else
                k_eff = value;
            fill   = 0;
            oldest = 0;
        endfunction

        function void insert_ordered(logic signed [SAMPLE_W-1:0] v, int unsigned count);
            int unsigned pos;
            pos = count;
            while (pos > 0 && ordered[pos-1] > v) begin
                ordered[pos] = ordered[pos-1];
                pos--;
            end
            ordered[pos] = v;
        endfunction

        // Only one copy of an equal value leaves the sorted row.
        function void remove_ordered(logic signed [SAMPLE_W-1:0] v, int unsigned count);
            int unsigned idx;
            idx = 0;
            while (idx < count && ordered[idx] != v)
                idx++;
            if (idx < count) begin
                for (; idx + 1 < count; idx++)
                    ordered[idx] = ordered[idx+1];
            end
        endfunction

        // Called for every accepted sample transaction.
        function void take_sample(logic signed [SAMPLE_W-1:0] s, logic restart);
            int unsigned p;
            if (restart) begin
                fill   = 0;
                oldest = 0;
            end
            if (fill < k_eff) begin
                ring[fill] = s;
                insert_ordered(s, fill);
                fill++;
                oldest = 0;
                if (fill < k_eff)
                    return;
            end else begin
                p = oldest;
                if (p >= k_eff)
                    p = 0;
                remove_ordered(ring[p], k_eff);
                insert_ordered(s, k_eff - 1);
                ring[p] = s;
                p++;
                if (p >= k_eff)
                    p = 0;
                oldest = p;
            end
            owed_medians.push_back(ordered[(k_eff - 1) / 2]);
        endfunction

        // Called for every accepted median transaction.
        function void check_median(logic signed [SAMPLE_W-1:0] actual);
            logic signed [SAMPLE_W-1:0] expected;
            if (owed_medians.size() == 0) begin
                $error("median: no result expected, actual %0d", actual);
                failures++;
                return;
            end
            expected = owed_medians.pop_front();
            medians_checked++;
            if (actual !== expected) begin
                $error("median mismatch: expected %0d, actual %0d", expected, actual);
                failures++;
            end
        endfunction

        function int outstanding();
            return owed_medians.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    swm_sample_if in_if ();
    swm_cfg_if    cfg_if ();
    swm_median_if out_if ();

    median_tracker tracker = new();

    bit quiet;
    bit hold_request;
    int samples_sent;
    int settings_used;

    sliding_window_median uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Known values on every input from time zero.
    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.sample       = '0;
        in_if.restart      = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.window_size = '0;
        out_if.ready       = 1'b0;
    end

    // Output side: ready with random stalls, plus one long requested hold.
    initial begin
        int burst_left;
        int hold_left;
        burst_left = 0;
        hold_left  = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready = 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                out_if.ready = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                burst_left   = $urandom_range(0, 6);
                out_if.ready = 1'b0;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    // Each median transaction is checked against the oldest owed value.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                tracker.check_median(out_if.median);
        end
    end

    // Offers one sample and returns at the falling edge after its transaction.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic restart);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        in_if.valid   = 1'b1;
        in_if.sample  = s;
        in_if.restart = restart;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.take_sample(s, restart);
        samples_sent++;
        @(negedge i_clk);
    endtask

    // Stops offering samples and waits until every owed median has arrived.
    task automatic drain_results();
        in_if.valid = 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge i_clk);
    endtask

    // The register is written only once the block has gone quiet.
    task automatic write_window_size(input logic [WIN_SIZE_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_if.valid       = 1'b1;
        cfg_if.window_size = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        tracker.set_window(value);
        settings_used++;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Mix of full-range values, clustered values that repeat, and extremes.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return int'($urandom_range(0, 8)) - 4;
            2: begin
                case ($urandom_range(0, 3))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // Main sequence.
    initial begin
        int size_plan [$];
        int phase;
        int phase_len;
        logic [WIN_SIZE_W-1:0] size_val;

        size_plan = '{0, 1, 2, 4, 5, 8, 64, 127, 65, 16, 31, 7, 63, 32, 6, 100};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: window of three with extremes, equal samples and a restart.
        write_window_size(WIN_SIZE_W'(3));
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(7, 1'b1);
        send_sample(7, 1'b0);
        send_sample(-7, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b0);

        // Directed: even window takes the lower median.
        write_window_size(WIN_SIZE_W'(2));
        send_sample(10, 1'b0);
        send_sample(20, 1'b0);
        send_sample(-5, 1'b0);

        // Directed: a zero size behaves as a window of one.
        write_window_size(WIN_SIZE_W'(0));
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b1);
        send_sample(0, 1'b0);

        // Random phases over the planned sizes, then random sizes.
        phase = 0;
        while (samples_sent < TOTAL_ITEMS) begin
            if (phase < size_plan.size())
                size_val = WIN_SIZE_W'(size_plan[phase]);
            else
                size_val = WIN_SIZE_W'($urandom_range(0, (1 << WIN_SIZE_W) - 1));
            write_window_size(size_val);
            phase_len = tracker.k_eff + $urandom_range(40, 80);
            for (int n = 0; n < phase_len && samples_sent < TOTAL_ITEMS; n++) begin
                if (samples_sent >= QUIET_AFTER)
                    quiet = 1'b1;
                if (phase == 1 && n == 10)
                    hold_request = 1'b1;
                if (phase == 3 && n == 20)
                    drain_results();
                send_sample(pick_sample(), $urandom_range(0, 49) == 0);
            end
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Covered %0d samples and %0d medians over %0d window size settings,",
                 samples_sent, tracker.medians_checked, settings_used);
        $display("including sizes 0, 1, 64 and 127, restarts and a full output stall.");
        if (tracker.failures == 0 && tracker.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/swm_pkg.sv
sv/swm_if.sv
sv/swm_cell.sv
sv/sliding_window_median.sv
bench/testbench.sv
